@@ rtl/rtse_pkg.sv @@
// Shared types and constants for the replay token store.
package rtse_pkg;

    localparam int KEY_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int KEY_W     = KEY_WORDS * WORD_W;
    localparam int KEY_BYTES_MAX = KEY_W / 8;

    // Slot numbers are carried at the width of the largest supported store.
    localparam int SLOT_W = 10;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REPLAY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

    typedef logic [WORD_W-1:0]                 stamp_t;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0]                 slot_t;

    // Scan token that walks down the row of cells.
    typedef struct packed {
        logic   valid;
        logic   have_free;
        slot_t  free_slot;
        logic   have_match;
        logic   have_victim;
        stamp_t victim_exp;
        slot_t  victim;
    } tok_t;

    // Write broadcast to all cells at the end of a scan.
    typedef struct packed {
        logic   en;
        slot_t  slot;
        stamp_t expiry;
    } wr_t;

endpackage

@@ rtl/rtse_cell.sv @@
// One store entry: holds a key and its expiry and updates the passing scan token.
module rtse_cell
    import rtse_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  tok_t   tok_in,
    output tok_t   tok_out,
    input  key_t   req_key,
    input  stamp_t req_now,
    input  wr_t    wr
);

    localparam slot_t MY_SLOT = slot_t'(IDX);

    key_t   key_reg;
    key_t   key_next;
    stamp_t exp_reg;
    stamp_t exp_next;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   occupied;
    logic   due;
    logic   live;

    assign occupied = (exp_reg != '0);
    assign due      = (exp_reg <= req_now);
    assign live     = occupied && !due;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid) begin
            if (!live) begin
                if (!tok_in.have_free) begin
                    tok_next.have_free = 1'b1;
                    tok_next.free_slot = MY_SLOT;
                end
            end else begin
                if (key_reg == req_key) begin
                    tok_next.have_match = 1'b1;
                end
                if (!tok_in.have_victim || (exp_reg < tok_in.victim_exp)) begin
                    tok_next.have_victim = 1'b1;
                    tok_next.victim_exp  = exp_reg;
                    tok_next.victim      = MY_SLOT;
                end
            end
        end
    end

    always_comb begin
        exp_next = exp_reg;
        key_next = key_reg;
        // A due entry is freed as the scan passes it.
        if (tok_in.valid && occupied && due) begin
            exp_next = '0;
        end
        if (wr.en && (wr.slot == MY_SLOT)) begin
            key_next = req_key;
            exp_next = wr.expiry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= '0;
            tok_reg <= '0;
        end else begin
            exp_reg <= exp_next;
            tok_reg <= tok_next;
        end
    end

    // The key is only looked at while the entry is live.
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/replay_token_store_with_expiry_core.sv @@
// An empty key goes from idle straight to the done state and is answered from there;
// any other request is answered once the scan token has walked the whole cell row.
// One request at a time: a new request is taken only in the idle state, and the done
// state waits while the output register still holds a result that is not yet taken.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) frees every entry and clears all control state.
module replay_token_store_with_expiry_core
    import rtse_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int KEY_BYTES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WORD_W-1:0]   s_key_word_0,
    input  logic [WORD_W-1:0]   s_key_word_1,
    input  logic [WORD_W-1:0]   s_key_word_2,
    input  logic [WORD_W-1:0]   s_key_word_3,
    input  logic [WORD_W-1:0]   s_expiry_time,
    input  logic [WORD_W-1:0]   s_current_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    key_t                key_reg;
    stamp_t              expiry_reg;
    stamp_t              now_reg;
    logic                start_reg;
    logic                start_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATUS_W-1:0] m_status_next;

    logic [KEY_W-1:0]    raw_flat;
    logic [KEY_W-1:0]    norm_flat;
    key_t                norm_key;
    logic                key_empty;
    logic                accept;

    tok_t                tok_chain [0:ENTRIES];
    tok_t                last_tok;
    wr_t                 wr;

    // Cut the key at its first zero byte and at the configured key length.
    always_comb begin
        logic ended;
        logic [7:0] cur;
        raw_flat  = {s_key_word_3, s_key_word_2, s_key_word_1, s_key_word_0};
        norm_flat = '0;
        ended     = 1'b0;
        for (int b = 0; b < KEY_BYTES_MAX; b++) begin
            cur = raw_flat[b*8 +: 8];
            if ((cur == 8'h00) || (b >= KEY_BYTES)) begin
                ended = 1'b1;
            end
            if (!ended) begin
                norm_flat[b*8 +: 8] = cur;
            end
        end
    end

    assign norm_key  = key_t'(norm_flat);
    assign key_empty = (norm_flat[7:0] == 8'h00);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // The token enters the row with only its valid bit set.
    assign tok_chain[0] = {start_reg, {($bits(tok_t)-1){1'b0}}};

    generate
        for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
            rtse_cell #(
                .IDX (i)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok_chain[i]),
                .tok_out (tok_chain[i+1]),
                .req_key (key_reg),
                .req_now (now_reg),
                .wr      (wr)
            );
        end
    endgenerate

    assign last_tok = tok_chain[ENTRIES];

    // The store write happens as the token leaves the last cell.
    always_comb begin
        wr.en     = last_tok.valid && !last_tok.have_match;
        wr.slot   = last_tok.have_free ? last_tok.free_slot : last_tok.victim;
        wr.expiry = expiry_reg;
    end

    always_comb begin
        state_next      = state_reg;
        start_next      = 1'b0;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (key_empty) begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end else begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (last_tok.valid) begin
                    res_status_next = last_tok.have_match ? STATUS_REPLAY : STATUS_STORED;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= norm_key;
            expiry_reg <= s_expiry_time;
            now_reg    <= s_current_time;
        end
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // A new result only appears when the control leaves the done state.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    // The scan token can only leave the row while a scan is running.
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        last_tok.valid |-> (state_reg == ST_SCAN))
        else $error("scan token seen outside a scan");

    // A full store always offers a victim to replace.
    a_victim_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_tok.valid && !last_tok.have_free) |-> last_tok.have_victim)
        else $error("store full without a victim");

endmodule
